FILE: hdl/esnap_pkg.sv
// Shared types and constants of the Ethernet II to LLC/SNAP encapsulator.
package esnap_pkg;

   localparam int unsigned MAX_PAYLOAD_W = 12;
   localparam int unsigned OFFSET_W      = 13;
   localparam int unsigned INDEX_W       = 16;
   localparam int unsigned STEP_W        = 4;

   localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 12'd1500;

   localparam logic [15:0] DIX_TYPE_THRESHOLD = 16'h0600;
   localparam logic [7:0]  SNAP_SAP           = 8'hAA;
   localparam logic [7:0]  SNAP_CTRL          = 8'h03;

   // Buffer layout.
   localparam logic [OFFSET_W-1:0] OFF_LEN_HI = 13'd14;
   localparam logic [OFFSET_W-1:0] OFF_SNAP   = 13'd16;

   // Status codes of the closing item.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [1:0] STATUS_SHORT    = 2'd2;

   localparam int unsigned CMD_FIFO_DEPTH = 4;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_ONE,
      WR_SNAP,
      WR_PAIR
   } wr_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic                is_status;
      logic [OFFSET_W-1:0] write_offset;
      logic [7:0]          write_value;
      logic [1:0]          status_code;
      logic [OFFSET_W-1:0] total_length;
      logic                run_end;
   } rsp_type;

   // One classified input byte, as handed from the front end to the back end.
   typedef struct packed {
      logic                hdr;       // two zero header bytes come first
      wr_kind_type         wr_kind;
      logic [OFFSET_W-1:0] wr_off;
      logic [7:0]          wr_val;
      logic [7:0]          type_hi;
      logic                has_end;
      logic [1:0]          code;
      logic                end_len;   // DIX length field is written at the end
      logic [OFFSET_W-1:0] len_field;
      logic [OFFSET_W-1:0] total;
   } cmd_type;

endpackage

FILE: hdl/esnap_front.sv
// Front end: takes frame bytes, tracks the frame state and classifies each byte.
module esnap_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  esnap_pkg::req_type                   req_data,
   input  logic [esnap_pkg::MAX_PAYLOAD_W-1:0]  max_payload,
   input  logic                                 fifo_full,
   output logic                                 push,
   output esnap_pkg::cmd_type                   cmd
);

   logic [esnap_pkg::INDEX_W-1:0]  byte_index_ff, byte_index_in;
   logic [7:0]                     held_ff, held_in;
   logic                           dix_ff, dix_in;
   logic                           ovf_ff, ovf_in;
   logic [esnap_pkg::OFFSET_W-1:0] limit;
   logic [esnap_pkg::OFFSET_W-1:0] idx_lo;
   logic                           accept;

   assign req_ready = !fifo_full;
   assign accept    = req_valid && req_ready;
   assign idx_lo    = byte_index_ff[esnap_pkg::OFFSET_W-1:0];

   always_comb begin
      cmd           = '0;
      cmd.wr_kind   = esnap_pkg::WR_NONE;
      byte_index_in = byte_index_ff;
      held_in       = held_ff;
      dix_in        = dix_ff;
      ovf_in        = ovf_ff;
      limit = {1'b0, max_payload} + (dix_ff ? 13'd13 : 13'd21);

      if (!ovf_ff) begin
         if (byte_index_ff < 16'd12) begin
            cmd.hdr     = (byte_index_ff == '0);
            cmd.wr_kind = esnap_pkg::WR_ONE;
            cmd.wr_off  = idx_lo + 13'd2;
            cmd.wr_val  = req_data.data_byte;
         end else if (byte_index_ff == 16'd12) begin
            held_in = req_data.data_byte;
         end else if (byte_index_ff == 16'd13) begin
            cmd.type_hi = held_ff;
            cmd.wr_val  = req_data.data_byte;
            if ({held_ff, req_data.data_byte} > esnap_pkg::DIX_TYPE_THRESHOLD) begin
               dix_in      = 1'b1;
               cmd.wr_kind = esnap_pkg::WR_SNAP;
            end else begin
               cmd.wr_kind = esnap_pkg::WR_PAIR;
            end
         end else if (byte_index_ff > {3'b000, limit}) begin
            ovf_in = 1'b1;
         end else begin
            cmd.wr_kind = esnap_pkg::WR_ONE;
            cmd.wr_off  = dix_ff ? idx_lo + 13'd10 : idx_lo + 13'd2;
            cmd.wr_val  = req_data.data_byte;
         end
      end

      if (req_data.frame_end) begin
         cmd.has_end = 1'b1;
         if (byte_index_ff < 16'd13) begin
            cmd.code = esnap_pkg::STATUS_SHORT;
         end else if (ovf_in) begin
            cmd.code = esnap_pkg::STATUS_TOO_LONG;
         end else begin
            cmd.code      = esnap_pkg::STATUS_OK;
            cmd.end_len   = dix_in;
            cmd.len_field = idx_lo - 13'd5;
            cmd.total     = dix_in ? idx_lo + 13'd11 : idx_lo + 13'd3;
         end
         byte_index_in = '0;
         held_in       = '0;
         dix_in        = 1'b0;
         ovf_in        = 1'b0;
      end else if (byte_index_ff != '1) begin
         byte_index_in = byte_index_ff + 16'd1;
      end
   end

   assign push = accept && ((cmd.wr_kind != esnap_pkg::WR_NONE) || cmd.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         held_ff       <= '0;
         dix_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
      end else if (accept) begin
         byte_index_ff <= byte_index_in;
         held_ff       <= held_in;
         dix_ff        <= dix_in;
         ovf_ff        <= ovf_in;
      end
   end

endmodule

FILE: hdl/esnap_cmd_fifo.sv
// Short command queue between the front end and the back end.
module esnap_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  esnap_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output esnap_pkg::cmd_type head_cmd
);

   localparam int unsigned PTR_W = $clog2(esnap_pkg::CMD_FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(esnap_pkg::CMD_FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(esnap_pkg::CMD_FIFO_DEPTH);

   esnap_pkg::cmd_type entries_ff [esnap_pkg::CMD_FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(esnap_pkg::CMD_FIFO_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(esnap_pkg::CMD_FIFO_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/esnap_back.sv
// Back end: expands each queued command into buffer writes and the status item.
module esnap_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  esnap_pkg::cmd_type head_cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output esnap_pkg::rsp_type rsp_data
);

   logic [esnap_pkg::STEP_W-1:0] step_ff, step_in;
   logic [esnap_pkg::STEP_W-1:0] n_hdr, n_wr, n_len, n_end, last, k, m;
   logic                         rsp_valid_ff;
   esnap_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic                         load;
   logic [7:0]                   snap_val;

   assign load = !empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      n_hdr = head_cmd.hdr ? 4'd2 : 4'd0;
      case (head_cmd.wr_kind)
         esnap_pkg::WR_ONE:  n_wr = 4'd1;
         esnap_pkg::WR_SNAP: n_wr = 4'd8;
         esnap_pkg::WR_PAIR: n_wr = 4'd2;
         default:            n_wr = 4'd0;
      endcase
      n_len = head_cmd.end_len ? 4'd2 : 4'd0;
      n_end = head_cmd.has_end ? 4'd1 : 4'd0;
      last  = n_hdr + n_wr + n_len + n_end - 4'd1;
      k     = step_ff - n_hdr;
      m     = k - n_wr;

      case (k[2:0]) inside
         3'd0, 3'd1: snap_val = esnap_pkg::SNAP_SAP;
         3'd2:       snap_val = esnap_pkg::SNAP_CTRL;
         3'd6:       snap_val = head_cmd.type_hi;
         3'd7:       snap_val = head_cmd.wr_val;
         default:    snap_val = 8'h00;
      endcase

      rsp_data_in = '0;
      if (step_ff < n_hdr) begin
         rsp_data_in.write_offset = {{(esnap_pkg::OFFSET_W-esnap_pkg::STEP_W){1'b0}}, step_ff};
      end else if (k < n_wr) begin
         case (head_cmd.wr_kind)
            esnap_pkg::WR_SNAP: begin
               rsp_data_in.write_offset = esnap_pkg::OFF_SNAP + {10'd0, k[2:0]};
               rsp_data_in.write_value  = snap_val;
            end
            esnap_pkg::WR_PAIR: begin
               rsp_data_in.write_offset = esnap_pkg::OFF_LEN_HI + {12'd0, k[0]};
               rsp_data_in.write_value  = k[0] ? head_cmd.wr_val : head_cmd.type_hi;
            end
            default: begin
               rsp_data_in.write_offset = head_cmd.wr_off;
               rsp_data_in.write_value  = head_cmd.wr_val;
            end
         endcase
      end else if (m < n_len) begin
         rsp_data_in.write_offset = esnap_pkg::OFF_LEN_HI + {12'd0, m[0]};
         rsp_data_in.write_value  = m[0] ? head_cmd.len_field[7:0]
                                         : {3'b000, head_cmd.len_field[12:8]};
      end else begin
         rsp_data_in.is_status    = 1'b1;
         rsp_data_in.status_code  = head_cmd.code;
         rsp_data_in.total_length = head_cmd.total;
      end
      rsp_data_in.run_end = (step_ff == last);

      step_in = (step_ff == last) ? '0 : step_ff + 4'd1;
   end

   assign pop       = load && (step_ff == last);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            step_ff      <= step_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: hdl/ethernet_dix_to_snap_encapsulator_top.sv
// Top level of the Ethernet II to 802.3 LLC/SNAP encapsulator.
//
//   Channel  Direction  Signals                        Carries
//   req      in         req_valid/req_ready/req_data   one frame byte and its end flag
//   rsp      out        rsp_valid/rsp_ready/rsp_data   one buffer write or the status item
//   csr      in         csr_write_enable/csr_write_data  the payload limit register
//
// Each accepted byte is classified in the cycle it arrives and queued; the back end
// delivers one result per cycle while rsp is not stalled, so bytes with one write each
// are taken at one byte per cycle. The type bytes of a DIX frame expand to eight writes
// and a closing DIX byte to up to eleven results; the back end delivers those one at a
// time, absorbed by the four-entry command queue. Results pass through the queue and
// the back end's output register. Reset is synchronous: it clears the frame state and
// the queue and loads the payload limit with 1500. A stall on rsp holds the output
// register; the queue then fills and req_ready falls.
module ethernet_dix_to_snap_encapsulator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  esnap_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output esnap_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write_enable,
   input  logic [esnap_pkg::MAX_PAYLOAD_W-1:0] csr_write_data
);

   // The user writes the payload limit only while the block is idle; the block does not enforce this.
   logic [esnap_pkg::MAX_PAYLOAD_W-1:0] max_payload_ff;

   logic               fifo_full;
   logic               fifo_empty;
   logic               push;
   logic               pop;
   esnap_pkg::cmd_type push_cmd;
   esnap_pkg::cmd_type head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= esnap_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_write_enable) begin
         max_payload_ff <= csr_write_data;
      end
   end

   // The front end keeps the byte position, the held type byte and the frame flags,
   // and turns each byte transfer that gives a result into a compact command.
   esnap_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .max_payload (max_payload_ff),
      .fifo_full   (fifo_full),
      .push        (push),
      .cmd         (push_cmd)
   );

   // Bytes that give no result, such as the held type byte or bytes after an
   // overflow, leave no entry in the queue.
   esnap_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .empty    (fifo_empty),
      .head_cmd (head_cmd)
   );

   // The back end steps through the results of the head command, one transfer per
   // cycle unless rsp stalls, and marks the last of them with run_end.
   esnap_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (fifo_empty),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
